// ===== rtl/plnsf_pkg.sv =====
// Shared types and constants for the power-law noise shaping filter.
// No dependencies; used by plnsf_mac, plnsf_hist and the top level.

package plnsf_pkg;

  // Configuration port data width and register field widths.
  localparam int DATA_W      = 32;
  localparam int CFG_ORDER_W = 6;
  localparam logic [CFG_ORDER_W-1:0] ORDER_RESET = 6'd16;

  // Register indexes, decoded from the word address.
  localparam logic REG_ORDER = 1'b0;
  localparam logic REG_BLUE  = 1'b1;

  // Request command codes.
  localparam logic [1:0] CMD_FILTER = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Control for the shared multiply-accumulate unit.
  typedef struct packed {
    logic clear;    // zero the accumulator
    logic valid;    // a tap enters the multiplier
    logic use_tap;  // the tap counts toward the sum
    logic sub;      // subtract the product instead of adding it
    logic last;     // final tap of the request
  } mac_ctl_t;

  // Control for the output history line.
  typedef struct packed {
    logic clear;    // zero every entry
    logic rotate;   // move every entry one place toward the head
    logic push;     // shift in a new output at the head
  } hist_ctl_t;

endpackage

// ===== rtl/plnsf_mac.sv =====
// Shared multiply-accumulate unit with round-to-nearest and saturation.
// Depends on plnsf_pkg for the control struct.

module plnsf_mac #(
  parameter int OP_W    = 17,
  parameter int COEFF_W = 18,
  parameter int ACC_W   = 41,
  parameter int FRAC    = 16,
  parameter int OUT_W   = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  plnsf_pkg::mac_ctl_t       ctl,
  input  logic signed [OP_W-1:0]    operand,
  input  logic signed [COEFF_W-1:0] coeff,
  output logic                      done,
  output logic [OUT_W-1:0]          y,
  output logic                      clip
);

  localparam int PROD_W = OP_W + COEFF_W;
  localparam logic signed [ACC_W-1:0] RND  = ACC_W'(64'd1 << (FRAC - 1));
  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

  logic signed [PROD_W-1:0] prod;
  logic                     p_valid;
  logic                     p_use;
  logic                     p_sub;
  logic                     p_last;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  rsum;
  logic signed [ACC_W-1:0]  shifted;
  logic                     over;
  logic                     under;

  // Product stage: one multiplication per cycle, registered.
  always_ff @(posedge clk) begin
    prod <= operand * coeff;
    if (rst) begin
      p_valid <= 1'b0;
      p_use   <= 1'b0;
      p_sub   <= 1'b0;
      p_last  <= 1'b0;
    end else begin
      p_valid <= ctl.valid;
      p_use   <= ctl.use_tap;
      p_sub   <= ctl.sub;
      p_last  <= ctl.last;
    end
  end

  assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

  // Accumulate stage; done marks that the last tap has been summed.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (p_valid && p_use) begin
      acc <= p_sub ? (acc - prod_ext) : (acc + prod_ext);
    end
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p_valid && p_last;
    end
  end

  // Round to nearest with ties upward, then clip to the output range.
  assign rsum    = acc + RND;
  assign shifted = rsum >>> FRAC;
  assign over    = shifted > SMAX;
  assign under   = shifted < SMIN;
  assign clip    = over || under;

  always_comb begin
    if (over) begin
      y = SMAX[OUT_W-1:0];
    end else if (under) begin
      y = SMIN[OUT_W-1:0];
    end else begin
      y = shifted[OUT_W-1:0];
    end
  end

endmodule

// ===== rtl/plnsf_hist.sv =====
// Output history line: the most recent outputs, newest at the head.
// Depends on plnsf_pkg for the control struct.

module plnsf_hist #(
  parameter int DEPTH = 31,
  parameter int W     = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  plnsf_pkg::hist_ctl_t ctl,
  input  logic [W-1:0]         din,
  output logic [W-1:0]         head
);

  logic [W-1:0] line [DEPTH];

  // Clear, push a new output, or rotate so each older entry reaches the head
  // in turn; a full rotation brings the line back to where it started.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int i = 0; i < DEPTH; i++) begin
        line[i] <= '0;
      end
    end else if (ctl.push) begin
      line[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end else if (ctl.rotate) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        line[i] <= line[i+1];
      end
      line[DEPTH-1] <= line[0];
    end
  end

  assign head = line[0];

endmodule

// ===== rtl/power_law_noise_shaping_filter.sv =====
// Top level of the power-law noise shaping filter: request sequencer,
// coefficient memory and configuration port. Uses plnsf_pkg, plnsf_mac, plnsf_hist.
//
// Usage: a request carries cmd, white_sample, coeff_index and coeff_value on the
// input channel (in_valid / in_stall). cmd 0 filters one white sample and returns
// one result (noise_out, saturated) on the output channel (out_valid / out_stall);
// cmd 1 writes one coefficient slot, cmd 2 clears the history and the previous
// white sample, cmd 3 is ignored. Loads, clears and ignored commands finish in the
// cycle they are accepted and return nothing.
// A filter request walks every tap slot through one shared multiplier, one slot per
// cycle, reading the coefficient memory port and the head of the rotating history;
// each slot passes the coefficient read and product registers into the accumulator.
// A new request is accepted only after the result has gone to the output register.
// If the receiver stalls, the result waits in the output register; the block keeps
// taking requests, but a new filter result is held back until the old one leaves.
// Reset clears the history, the previous white sample and the handshake state and
// sets filter_order to 16 and blue_mode to 0; coefficients must be loaded before use.
// Registers: filter_order at byte address 0, blue_mode at byte address 4.

module power_law_noise_shaping_filter #(
  parameter int MAX_ORDER   = 32,
  parameter int SAMPLE_BITS = 16,
  parameter int COEFF_BITS  = 18
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [plnsf_pkg::DATA_W-1:0]        pwdata,
  output logic [plnsf_pkg::DATA_W-1:0]        prdata,
  output logic                                pready,
  // Request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          cmd,
  input  logic signed [SAMPLE_BITS-1:0]       white_sample,
  input  logic [$clog2(MAX_ORDER)-1:0]        coeff_index,
  input  logic signed [COEFF_BITS-1:0]        coeff_value,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS-1:0]       noise_out,
  output logic                                saturated
);

  localparam int IDX_W = $clog2(MAX_ORDER);
  localparam int ORD_W = $clog2(MAX_ORDER + 1);
  localparam int OP_W  = SAMPLE_BITS + 1;
  localparam int FRAC  = COEFF_BITS - 2;
  localparam int ACC_W = OP_W + COEFF_BITS + IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_K = IDX_W'(MAX_ORDER - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  state_t                               state;
  logic [plnsf_pkg::CFG_ORDER_W-1:0]    filter_order;
  logic                                 blue_mode;
  logic [ORD_W-1:0]                     order_eff;
  logic [ORD_W-1:0]                     order_next;
  logic signed [OP_W-1:0]               x_reg;
  logic signed [OP_W-1:0]               x_next;
  logic signed [SAMPLE_BITS-1:0]        prev_white;
  logic [IDX_W-1:0]                     issue_k;
  logic                                 issue_act;
  logic                                 s1_valid;
  logic [IDX_W-1:0]                     s1_k;
  logic signed [COEFF_BITS-1:0]         coef_mem [MAX_ORDER];
  logic signed [COEFF_BITS-1:0]         coeff_rd;
  logic                                 accept;
  logic                                 cfg_write;
  logic                                 out_free;
  logic signed [OP_W-1:0]               operand;
  logic [SAMPLE_BITS-1:0]               hist_head;
  logic [SAMPLE_BITS-1:0]               mac_y;
  logic                                 mac_clip;
  logic                                 mac_done;
  plnsf_pkg::mac_ctl_t                  mac_ctl;
  plnsf_pkg::hist_ctl_t                 hist_ctl;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // Configuration registers and read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_order <= plnsf_pkg::ORDER_RESET;
      blue_mode    <= 1'b0;
    end else if (cfg_write) begin
      if (paddr[2] == plnsf_pkg::REG_ORDER) begin
        filter_order <= pwdata[plnsf_pkg::CFG_ORDER_W-1:0];
      end else begin
        blue_mode <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == plnsf_pkg::REG_BLUE) ?
                  plnsf_pkg::DATA_W'(blue_mode) : plnsf_pkg::DATA_W'(filter_order);

  // Clamp the tap count into the supported range.
  always_comb begin
    if (int'(filter_order) < 2) begin
      order_next = ORD_W'(2);
    end else if (int'(filter_order) > MAX_ORDER) begin
      order_next = ORD_W'(MAX_ORDER);
    end else begin
      order_next = ORD_W'(filter_order);
    end
  end

  // Input tap: the white sample, or in blue mode the previous one minus it.
  assign x_next = blue_mode ?
                  ({prev_white[SAMPLE_BITS-1], prev_white} -
                   {white_sample[SAMPLE_BITS-1], white_sample}) :
                  {white_sample[SAMPLE_BITS-1], white_sample};

  // Coefficient memory: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (accept && cmd == plnsf_pkg::CMD_LOAD &&
        int'(coeff_index) < MAX_ORDER) begin
      coef_mem[coeff_index] <= coeff_value;
    end
    coeff_rd <= coef_mem[issue_k];
  end

  // Sequencer: issue every tap slot once, then wait for the sum and hand it out.
  always_ff @(posedge clk) begin
    if (accept && cmd == plnsf_pkg::CMD_FILTER) begin
      x_reg     <= x_next;
      order_eff <= order_next;
    end
    if (rst) begin
      state      <= ST_IDLE;
      issue_k    <= '0;
      issue_act  <= 1'b0;
      s1_valid   <= 1'b0;
      s1_k       <= '0;
      prev_white <= '0;
      out_valid  <= 1'b0;
      noise_out  <= '0;
      saturated  <= 1'b0;
    end else begin
      // The finishing state reloads the output register itself.
      if (out_valid && !out_stall && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      s1_valid <= issue_act;
      s1_k     <= issue_k;
      case (state)
        ST_IDLE: begin
          if (accept && cmd == plnsf_pkg::CMD_FILTER) begin
            state     <= ST_RUN;
            issue_k   <= '0;
            issue_act <= 1'b1;
            if (blue_mode) begin
              prev_white <= white_sample;
            end
          end else if (accept && cmd == plnsf_pkg::CMD_CLEAR) begin
            prev_white <= '0;
          end
        end
        ST_RUN: begin
          if (issue_act) begin
            if (issue_k == LAST_K) begin
              issue_act <= 1'b0;
            end else begin
              issue_k <= issue_k + IDX_W'(1);
            end
          end
          if (mac_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            noise_out <= mac_y;
            saturated <= mac_clip;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Tap operand: the input tap first, then the history head as it rotates.
  assign operand = (s1_k == '0) ? x_reg :
                   {hist_head[SAMPLE_BITS-1], hist_head};

  always_comb begin
    mac_ctl.clear   = accept && cmd == plnsf_pkg::CMD_FILTER;
    mac_ctl.valid   = s1_valid;
    mac_ctl.use_tap = ORD_W'(s1_k) < order_eff;
    mac_ctl.sub     = s1_k != '0;
    mac_ctl.last    = s1_valid && s1_k == LAST_K;
  end

  always_comb begin
    hist_ctl.clear  = accept && cmd == plnsf_pkg::CMD_CLEAR;
    hist_ctl.rotate = s1_valid && s1_k != '0;
    hist_ctl.push   = state == ST_FIN && out_free;
  end

  plnsf_mac #(
    .OP_W    (OP_W),
    .COEFF_W (COEFF_BITS),
    .ACC_W   (ACC_W),
    .FRAC    (FRAC),
    .OUT_W   (SAMPLE_BITS)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mac_ctl),
    .operand (operand),
    .coeff   (coeff_rd),
    .done    (mac_done),
    .y       (mac_y),
    .clip    (mac_clip)
  );

  plnsf_hist #(
    .DEPTH (MAX_ORDER - 1),
    .W     (SAMPLE_BITS)
  ) u_hist (
    .clk  (clk),
    .rst  (rst),
    .ctl  (hist_ctl),
    .din  (mac_y),
    .head (hist_head)
  );

`ifndef SYNTH
  // The sum completes only while a filter request is in flight.
  assert property (@(posedge clk) disable iff (rst) mac_done |-> state == ST_RUN)
    else $error("accumulator finished outside a filter request");

  // Taps are issued and rotate the history only while busy.
  assert property (@(posedge clk) disable iff (rst)
                   (issue_act || s1_valid) |-> state == ST_RUN)
    else $error("tap issued while not running");

  // A filter request starts its walk at the input tap.
  assert property (@(posedge clk) disable iff (rst)
                   (accept && cmd == plnsf_pkg::CMD_FILTER) |=>
                   (state == ST_RUN && issue_act && issue_k == '0))
    else $error("filter request did not start at the first tap");

  // Finishing with a free output register always presents the result.
  assert property (@(posedge clk) disable iff (rst)
                   (state == ST_FIN && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("finished result was not handed to the output");
`endif

endmodule
